@@ rtl/lkvc_pkg.sv @@
// Shared constants and types for the LRU key-value cache.
// No dependencies; imported by every module of the cache.
package lkvc_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int           CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic is_put;
        logic hit;
        logic evict;
        logic insert;
    } lkvc_ctl_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// LRU key-value cache: input register, combinational lookup with store update, result register.
// The result register is loaded when the held item is processed, which waits while the output is stalled.
// Accepts one item per cycle while out_ready does not stall the output; lookup and rank update happen together.
// Reset: store empty, capacity 16. A capacity write also empties the store.
// Depends on lkvc_pkg, lkvc_lookup, lkvc_store.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = lkvc_pkg::DEF_VALUE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic signed [KEY_BITS-1:0]   key,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic signed [VALUE_BITS-1:0] read_value,
    output logic                         evicted,
    output logic signed [KEY_BITS-1:0]   evicted_key
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    logic                  in_full_reg;
    logic                  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] rd_reg;
    logic                  ev_reg;
    logic [KEY_BITS-1:0]   evk_reg;
    logic                  process;

    lkvc_ctl_t              ctl;
    logic [MAX_ENTRIES-1:0] match_oh;
    logic [MAX_ENTRIES-1:0] slot_oh;
    logic [RANK_W-1:0]      found_rank;
    logic [VALUE_BITS-1:0]  lk_read_value;
    logic [KEY_BITS-1:0]    lk_evicted_key;
    logic [MAX_ENTRIES-1:0] entry_valid;
    logic [KEY_BITS-1:0]    entry_key   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]  entry_value [MAX_ENTRIES];
    logic [RANK_W-1:0]      entry_rank  [MAX_ENTRIES];
    logic [CNT_W-1:0]       entry_count;

    assign process  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            if (in_valid && in_ready)
                in_full_reg <= 1'b1;
            else if (process)
                in_full_reg <= 1'b0;
            if (process)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            key_reg   <= key;
            value_reg <= value;
        end
        if (process)
        begin
            hit_reg <= ctl.hit;
            rd_reg  <= lk_read_value;
            ev_reg  <= ctl.evict;
            evk_reg <= lk_evicted_key;
        end
    end

    lkvc_lookup #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_lookup (
        .kind       (kind_reg),
        .key        (key_reg),
        .capacity   (cap_reg),
        .entry_valid(entry_valid),
        .entry_key  (entry_key),
        .entry_value(entry_value),
        .entry_rank (entry_rank),
        .entry_count(entry_count),
        .ctl        (ctl),
        .match_oh   (match_oh),
        .slot_oh    (slot_oh),
        .found_rank (found_rank),
        .read_value (lk_read_value),
        .evicted_key(lk_evicted_key)
    );

    lkvc_store #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cfg_we),
        .upd        (process),
        .ctl        (ctl),
        .match_oh   (match_oh),
        .slot_oh    (slot_oh),
        .found_rank (found_rank),
        .wr_key     (key_reg),
        .wr_value   (value_reg),
        .entry_valid(entry_valid),
        .entry_key  (entry_key),
        .entry_value(entry_value),
        .entry_rank (entry_rank),
        .entry_count(entry_count)
    );

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = rd_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evk_reg;

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg) |-> !hit_reg)
        else $error("eviction reported on a hit");

    a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ev_reg) |-> (evk_reg == '0))
        else $error("evicted key nonzero without eviction");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule

@@ rtl/lkvc_lookup.sv @@
// Parallel key match, victim and free slot selection, result data muxing.
// Depends on lkvc_pkg.
module lkvc_lookup #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                             kind,
    input  logic [KEY_BITS-1:0]              key,
    input  logic [lkvc_pkg::CAP_W-1:0]       capacity,
    input  logic [MAX_ENTRIES-1:0]           entry_valid,
    input  logic [KEY_BITS-1:0]              entry_key [MAX_ENTRIES],
    input  logic [VALUE_BITS-1:0]            entry_value [MAX_ENTRIES],
    input  logic [$clog2(MAX_ENTRIES)-1:0]   entry_rank [MAX_ENTRIES],
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
    output lkvc_pkg::lkvc_ctl_t              ctl,
    output logic [MAX_ENTRIES-1:0]           match_oh,
    output logic [MAX_ENTRIES-1:0]           slot_oh,
    output logic [$clog2(MAX_ENTRIES)-1:0]   found_rank,
    output logic [VALUE_BITS-1:0]            read_value,
    output logic [KEY_BITS-1:0]              evicted_key
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] victim_vec;
    logic [MAX_ENTRIES-1:0] victim_oh;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] free_oh;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic                   full;
    logic                   miss_put;
    logic [VALUE_BITS-1:0]  hit_value;
    logic [KEY_BITS-1:0]    victim_key;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_vec[i]  = entry_valid[i] && (entry_key[i] == key);
            victim_vec[i] = entry_valid[i] &&
                            (CNT_W'(entry_rank[i]) + CNT_W'(1) == entry_count);
            free_vec[i]   = !entry_valid[i];
        end
    end

    // lowest set bit
    assign match_oh  = match_vec  & ~(match_vec  - MAX_ENTRIES'(1));
    assign victim_oh = victim_vec & ~(victim_vec - MAX_ENTRIES'(1));
    assign free_oh   = free_vec   & ~(free_vec   - MAX_ENTRIES'(1));

    always_comb
    begin
        hit_value  = '0;
        victim_key = '0;
        found_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit_value  = hit_value  | (entry_value[i] & {VALUE_BITS{match_oh[i]}});
            victim_key = victim_key | (entry_key[i]   & {KEY_BITS{victim_oh[i]}});
            found_rank = found_rank | (entry_rank[i]  & {RANK_W{match_oh[i]}});
        end
    end

    assign cap_ext = CMP_W'(capacity);
    always_comb
    begin
        if (cap_ext == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
            eff_cap = CMP_W'(MAX_ENTRIES);
        else
            eff_cap = cap_ext;
    end
    assign full = CMP_W'(entry_count) >= eff_cap;

    assign miss_put   = (kind == KIND_PUT) && !(|match_vec);
    assign ctl.is_put = (kind == KIND_PUT);
    assign ctl.hit    = |match_vec;
    assign ctl.evict  = miss_put && full && (|victim_vec);
    assign ctl.insert = miss_put && (ctl.evict || (|free_vec));
    assign slot_oh    = ctl.evict ? victim_oh : free_oh;

    assign read_value  = (ctl.hit && kind == KIND_GET) ? hit_value : '1;
    assign evicted_key = ctl.evict ? victim_key : '0;

endmodule

@@ rtl/lkvc_store.sv @@
// Entry storage: valid bits, keys, values, recency ranks and fill count.
// Depends on lkvc_pkg; updated from lkvc_lookup decisions.
module lkvc_store #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic                             upd,
    input  lkvc_pkg::lkvc_ctl_t              ctl,
    input  logic [MAX_ENTRIES-1:0]           match_oh,
    input  logic [MAX_ENTRIES-1:0]           slot_oh,
    input  logic [$clog2(MAX_ENTRIES)-1:0]   found_rank,
    input  logic [KEY_BITS-1:0]              wr_key,
    input  logic [VALUE_BITS-1:0]            wr_value,
    output logic [MAX_ENTRIES-1:0]           entry_valid,
    output logic [KEY_BITS-1:0]              entry_key [MAX_ENTRIES],
    output logic [VALUE_BITS-1:0]            entry_value [MAX_ENTRIES],
    output logic [$clog2(MAX_ENTRIES)-1:0]   entry_rank [MAX_ENTRIES],
    output logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]      rank_reg  [MAX_ENTRIES];
    logic [RANK_W-1:0]      rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [KEY_BITS-1:0]    key_reg   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]  value_reg [MAX_ENTRIES];

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (clear)
        begin
            valid_next = '0;
            count_next = '0;
        end
        else if (upd && ctl.hit)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (match_oh[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && rank_reg[i] < found_rank)
                    rank_next[i] = RANK_W'(rank_reg[i] + 1'b1);
            end
        end
        else if (upd && ctl.insert)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (slot_oh[i])
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i])
                    rank_next[i] = RANK_W'(rank_reg[i] + 1'b1);
            end
            if (!ctl.evict)
                count_next = CNT_W'(count_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (upd && ctl.insert && slot_oh[i])
            begin
                key_reg[i]   <= wr_key;
                value_reg[i] <= wr_value;
            end
            else if (upd && ctl.hit && ctl.is_put && match_oh[i])
                value_reg[i] <= wr_value;
        end
    end

    assign entry_valid = valid_reg;
    assign entry_key   = key_reg;
    assign entry_value = value_reg;
    assign entry_rank  = rank_reg;
    assign entry_count = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count disagrees with valid bits");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (count_reg == '0 && valid_reg == '0))
        else $error("capacity write did not empty the store");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> $onehot0(match_oh))
        else $error("more than one entry matched");

endmodule
